### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ARW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anti-replay check: assertion failed");

// Next-cycle implication.
`define ARW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anti-replay check: assertion failed");

`endif

### hw/rtl/arw_pkg.sv
package arw_pkg;

    // Window geometry
    localparam int WINDOW_SIZE  = 32;
    localparam int SEQ_W        = 32;
    localparam int POS_W        = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W        = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W        = CNT_W + 1;

    // Leading-run scan works one chunk per cycle
    localparam int CHUNK_W      = 8;
    localparam int TCNT_W       = $clog2(CHUNK_W + 1);
    localparam int NUM_CHUNKS   = (WINDOW_SIZE + CHUNK_W - 1) / CHUNK_W;
    localparam int CHUNK_IDX_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int ROT_W        = NUM_CHUNKS * CHUNK_W;

    // Request kinds
    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture request fields
        logic calc;         // initial latch, offset, bit position, or clear
        logic mark;         // duplicate test, set bit, rotate bitmap
        logic scan_step;    // one chunk of the leading-run scan
        logic wrap;         // write bitmap back, advance head and start
        logic load_result;  // move decision into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic over;
        logic dup;
        logic head_set;
        logic scan_done;
    } status_t;

endpackage

### hw/rtl/anti_replay_window_check.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   kind, seq_num
// output    out_valid / out_ready rejected
//
// One request at a time. A clear or out-of-window check runs the calc state, a
// duplicate or non-sliding check calc and mark, and a sliding check also the
// scan and wrap states: the leading-run scan covers 8 bitmap bits per cycle.
// Reset (rst_n low) empties the window; no clearing pass is needed.
// A waiting result does not block the next request; only a second finished
// result stalls until out_ready takes the first.
`include "assert_macros.svh"

module anti_replay_window_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic [arw_pkg::SEQ_W-1:0]  seq_num,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       rejected
);

    arw_pkg::cmd_t     cmd;
    arw_pkg::status_t  status;

    arw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    arw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (kind),
        .seq_num   (seq_num),
        .rejected  (rejected)
    );

    // Controller issues at most one datapath command per cycle
    `ARW_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd))
    // A request in flight blocks the input side
    `ARW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A loaded result is presented
    `ARW_ASSERT_NEXT(a_result_shown, cmd.load_result, out_valid)
    // A taken result is not shown twice
    `ARW_ASSERT_NEXT(a_no_repeat, out_valid && out_ready && !cmd.load_result, !out_valid)

endmodule

### hw/rtl/arw_datapath.sv
module arw_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  arw_pkg::cmd_t              cmd,
    output arw_pkg::status_t           status,
    input  logic                       kind,
    input  logic [arw_pkg::SEQ_W-1:0]  seq_num,
    output logic                       rejected
);

    // Window state
    logic [arw_pkg::SEQ_W-1:0]        start_reg;
    logic [arw_pkg::POS_W-1:0]        head_reg;
    logic [arw_pkg::WINDOW_SIZE-1:0]  seen_reg;

    // Per-request working registers
    logic                             kind_reg;
    logic [arw_pkg::SEQ_W-1:0]        seq_reg;
    logic [arw_pkg::POS_W-1:0]        pos_reg;
    logic [arw_pkg::ROT_W-1:0]        rot_reg;
    logic [arw_pkg::CNT_W-1:0]        cnt_reg;
    logic [arw_pkg::CHUNK_IDX_W-1:0]  chunk_reg;
    logic                             rej_pend_reg;
    logic                             rejected_reg;

    // Calc stage signals
    logic                             latch_start;
    logic [arw_pkg::SEQ_W-1:0]        eff_start;
    logic [arw_pkg::POS_W-1:0]        eff_head;
    logic [arw_pkg::SEQ_W-1:0]        offset;
    logic                             over;
    logic [arw_pkg::POS_W:0]          pos_sum;
    logic [arw_pkg::POS_W-1:0]        pos_next;

    // Mark stage signals
    logic [arw_pkg::WINDOW_SIZE-1:0]  seen_set;
    logic [arw_pkg::ROT_W-1:0]        rot_next;

    // Scan stage signals
    logic [arw_pkg::CHUNK_W-1:0]      chunk_bits;
    logic [arw_pkg::CHUNK_W-1:0]      chunk_clr;
    logic [arw_pkg::TCNT_W-1:0]       run_len;
    logic                             chunk_last;

    // Wrap stage signals
    logic [arw_pkg::WINDOW_SIZE-1:0]  seen_back;
    logic [arw_pkg::SUM_W-1:0]        head_sum;
    logic [arw_pkg::POS_W-1:0]        head_adv;

    // Initial latch, offset and target bit position
    always_comb
    begin
        latch_start = (start_reg == '0) && !seen_reg[0];
        eff_start   = latch_start ? seq_reg : start_reg;
        eff_head    = latch_start ? '0 : head_reg;
        offset      = seq_reg - eff_start;
        over        = offset > arw_pkg::SEQ_W'(arw_pkg::WINDOW_SIZE - 1);
        pos_sum     = {1'b0, eff_head} + {1'b0, offset[arw_pkg::POS_W-1:0]};
        if (pos_sum >= (arw_pkg::POS_W+1)'(arw_pkg::WINDOW_SIZE))
        begin
            pos_sum = pos_sum - (arw_pkg::POS_W+1)'(arw_pkg::WINDOW_SIZE);
        end
        pos_next    = pos_sum[arw_pkg::POS_W-1:0];
    end

    // Set target bit; rotate so the head lands at bit 0
    always_comb
    begin
        logic [arw_pkg::POS_W:0] idx;
        seen_set           = seen_reg;
        seen_set[pos_reg]  = 1'b1;
        rot_next           = '0;
        for (int i = 0; i < arw_pkg::WINDOW_SIZE; i++)
        begin
            idx = (arw_pkg::POS_W+1)'(i) + {1'b0, head_reg};
            if (idx >= (arw_pkg::POS_W+1)'(arw_pkg::WINDOW_SIZE))
            begin
                idx = idx - (arw_pkg::POS_W+1)'(arw_pkg::WINDOW_SIZE);
            end
            rot_next[i] = seen_set[idx[arw_pkg::POS_W-1:0]];
        end
    end

    // Trailing-ones count of the current chunk, and the chunk with that run cleared
    always_comb
    begin
        logic run;
        chunk_bits = rot_reg[chunk_reg*arw_pkg::CHUNK_W +: arw_pkg::CHUNK_W];
        chunk_clr  = chunk_bits;
        run_len    = '0;
        run        = 1'b1;
        for (int i = 0; i < arw_pkg::CHUNK_W; i++)
        begin
            if (run && chunk_bits[i])
            begin
                run_len      = run_len + 1'b1;
                chunk_clr[i] = 1'b0;
            end
            else
            begin
                run = 1'b0;
            end
        end
        chunk_last = (chunk_reg == arw_pkg::CHUNK_IDX_W'(arw_pkg::NUM_CHUNKS - 1));
    end

    // Rotate back and advance the head past the cleared run
    always_comb
    begin
        logic [arw_pkg::POS_W:0] idx;
        for (int j = 0; j < arw_pkg::WINDOW_SIZE; j++)
        begin
            idx = (arw_pkg::POS_W+1)'(j) + (arw_pkg::POS_W+1)'(arw_pkg::WINDOW_SIZE)
                  - {1'b0, head_reg};
            if (idx >= (arw_pkg::POS_W+1)'(arw_pkg::WINDOW_SIZE))
            begin
                idx = idx - (arw_pkg::POS_W+1)'(arw_pkg::WINDOW_SIZE);
            end
            seen_back[j] = rot_reg[idx[arw_pkg::POS_W-1:0]];
        end
        head_sum = arw_pkg::SUM_W'(head_reg) + arw_pkg::SUM_W'(cnt_reg);
        if (head_sum >= arw_pkg::SUM_W'(arw_pkg::WINDOW_SIZE))
        begin
            head_sum = head_sum - arw_pkg::SUM_W'(arw_pkg::WINDOW_SIZE);
        end
        head_adv = head_sum[arw_pkg::POS_W-1:0];
    end

    // Status back to the controller
    always_comb
    begin
        status.is_clear  = (kind_reg == arw_pkg::KIND_CLEAR);
        status.over      = over;
        status.dup       = seen_reg[pos_reg];
        status.head_set  = seen_set[head_reg];
        status.scan_done = (run_len != arw_pkg::TCNT_W'(arw_pkg::CHUNK_W)) || chunk_last;
    end

    // Window state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            head_reg  <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (cmd.calc)
            begin
                if (kind_reg == arw_pkg::KIND_CLEAR)
                begin
                    start_reg <= '0;
                    head_reg  <= '0;
                    seen_reg  <= '0;
                end
                else
                begin
                    start_reg <= eff_start;
                    head_reg  <= eff_head;
                end
            end
            if (cmd.mark && !seen_reg[pos_reg])
            begin
                seen_reg <= seen_set;
            end
            if (cmd.wrap)
            begin
                seen_reg  <= seen_back;
                head_reg  <= head_adv;
                start_reg <= start_reg + arw_pkg::SEQ_W'(cnt_reg);
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            seq_reg  <= seq_num;
        end
        if (cmd.calc)
        begin
            pos_reg      <= pos_next;
            rej_pend_reg <= (kind_reg == arw_pkg::KIND_CHECK) && over;
        end
        if (cmd.mark)
        begin
            rej_pend_reg <= seen_reg[pos_reg];
            rot_reg      <= rot_next;
            cnt_reg      <= '0;
            chunk_reg    <= '0;
        end
        if (cmd.scan_step)
        begin
            rot_reg[chunk_reg*arw_pkg::CHUNK_W +: arw_pkg::CHUNK_W] <= chunk_clr;
            cnt_reg   <= cnt_reg + arw_pkg::CNT_W'(run_len);
            chunk_reg <= chunk_reg + 1'b1;
        end
        if (cmd.load_result)
        begin
            rejected_reg <= rej_pend_reg;
        end
    end

    assign rejected = rejected_reg;

endmodule

### hw/rtl/arw_ctrl.sv
module arw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  arw_pkg::status_t  status,
    output arw_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CALC   = 3'd1;
    localparam logic [2:0] S_MARK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_WRAP   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc = 1'b1;
                if (status.is_clear || status.over)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (status.dup || !status.head_set)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

    typedef struct {
        logic                       kind;
        logic [arw_pkg::SEQ_W-1:0]  seq;
        logic                       rejected;
    } verdict_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       kind;
    logic [arw_pkg::SEQ_W-1:0]  seq_num;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       rejected;

    // Window model state
    logic [arw_pkg::SEQ_W-1:0]        win_start;
    logic [arw_pkg::POS_W-1:0]        head_pos;
    logic [arw_pkg::WINDOW_SIZE-1:0]  seen_map;

    verdict_t     expected_verdicts[$];
    idle_mode_t   idle_mode;
    int unsigned  ready_hold;
    int           err_count;

    anti_replay_window_check u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .seq_num   (seq_num),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rejected  (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycles of idling for one request or one result
    function automatic int unsigned draw_idle();
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default:    return $urandom_range(0, 19);
        endcase
    endfunction

    // Window update for one request; returns the expected reject flag
    function logic predict_rejected(input logic k, input logic [arw_pkg::SEQ_W-1:0] s);
        logic [arw_pkg::SEQ_W-1:0] offset;
        int                        pos;
        bit                        slid;
        if (k == arw_pkg::KIND_CLEAR)
        begin
            win_start = '0;
            head_pos  = '0;
            seen_map  = '0;
            return 1'b0;
        end
        // first check after clear anchors the window
        if (win_start == '0 && !seen_map[0])
        begin
            win_start = s;
            head_pos  = '0;
        end
        offset = s - win_start;
        if (offset > arw_pkg::WINDOW_SIZE - 1)
            return 1'b1;
        pos = (int'(head_pos) + int'(offset)) % arw_pkg::WINDOW_SIZE;
        if (seen_map[pos])
            return 1'b1;
        seen_map[pos] = 1'b1;
        // slide past the leading run of received numbers
        if (seen_map[head_pos])
        begin
            slid = 1'b0;
            for (int i = 0; i < arw_pkg::WINDOW_SIZE; i++)
            begin
                pos = (int'(head_pos) + i) % arw_pkg::WINDOW_SIZE;
                if (seen_map[pos])
                    seen_map[pos] = 1'b0;
                else
                begin
                    head_pos  = pos;
                    win_start = win_start + i;
                    slid      = 1'b1;
                    break;
                end
            end
            if (!slid)
                win_start = win_start + arw_pkg::WINDOW_SIZE;
        end
        return 1'b0;
    endfunction

    // Drive one request and record its expected verdict once accepted
    task automatic send_request(input logic k, input logic [arw_pkg::SEQ_W-1:0] s);
        int unsigned gap;
        verdict_t    v;
        gap = draw_idle();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        seq_num  <= s;
        do
            @(posedge clk);
        while (!in_ready);
        v.kind     = k;
        v.seq      = s;
        v.rejected = predict_rejected(k, s);
        expected_verdicts.push_back(v);
    endtask

    // Hold off the sender until every verdict is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Result side: compare and draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: result with nothing pending, got rejected=%0b",
                             $time, rejected);
                    err_count++;
                end
                else
                begin
                    verdict_t v;
                    v = expected_verdicts.pop_front();
                    if (rejected !== v.rejected)
                    begin
                        $display("%0t: rejected mismatch (kind %0b seq %h), expected %0b, got %0b",
                                 $time, v.kind, v.seq, v.rejected, rejected);
                        err_count++;
                    end
                end
                ready_hold = draw_idle();
                if (ready_hold != 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (ready_hold != 0)
                    ready_hold--;
                if (ready_hold == 0)
                    out_ready <= 1'b1;
            end
        end
    end

    // Anchor on first check, then in-window, duplicate and out-of-window numbers
    task automatic test_initial_latch();
        send_request(arw_pkg::KIND_CHECK, 32'd1000);
        send_request(arw_pkg::KIND_CHECK, 32'd1000);
        send_request(arw_pkg::KIND_CHECK, 32'd1001);
        send_request(arw_pkg::KIND_CHECK, 32'd1002 + arw_pkg::WINDOW_SIZE - 1);
        send_request(arw_pkg::KIND_CHECK, 32'd1002 + arw_pkg::WINDOW_SIZE);
        send_request(arw_pkg::KIND_CHECK, 32'd1001);
        send_request(arw_pkg::KIND_CHECK, 32'd1002 + arw_pkg::WINDOW_SIZE - 1);
        send_request(arw_pkg::KIND_CHECK, 32'd1003);
        send_request(arw_pkg::KIND_CHECK, 32'd1002);
    endtask

    // Fill every slot out of order so the head arrives last
    task automatic test_full_window();
        send_request(arw_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_5000);
        for (int i = 2; i <= arw_pkg::WINDOW_SIZE; i++)
            send_request(arw_pkg::KIND_CHECK, 32'h0000_5000 + i);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_5001);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_5001 + arw_pkg::WINDOW_SIZE);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_5000 + arw_pkg::WINDOW_SIZE);
    endtask

    // Window start crossing 2^32, including the re-anchor at zero
    task automatic test_seq_wrap();
        send_request(arw_pkg::KIND_CLEAR, 32'h0);
        send_request(arw_pkg::KIND_CHECK, 32'hFFFF_FFFC);
        send_request(arw_pkg::KIND_CHECK, 32'hFFFF_FFFE);
        send_request(arw_pkg::KIND_CHECK, 32'hFFFF_FFFD);
        send_request(arw_pkg::KIND_CHECK, 32'hFFFF_FFFF);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_0001);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_0000);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_0001);
    endtask

    // Field extremes: zero, all ones, clear with payload set
    task automatic test_extremes();
        send_request(arw_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_0000);
        send_request(arw_pkg::KIND_CHECK, 32'hFFFF_FFFF);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_0000);
        send_request(arw_pkg::KIND_CLEAR, 32'h0000_0000);
        send_request(arw_pkg::KIND_CHECK, 32'hFFFF_FFFF);
        send_request(arw_pkg::KIND_CHECK, 32'h0000_0000);
    endtask

    // Mostly near-window traffic skewed to small offsets, plus noise and clears
    task automatic test_random_traffic();
        int unsigned pick;
        for (int n = 0; n < 1500; n++)
        begin
            if (n % 100 == 0)
                idle_mode = idle_mode_t'($urandom_range(0, 2));
            if (n == 750)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_request(arw_pkg::KIND_CLEAR, $urandom);
            else if (pick < 10)
                send_request(arw_pkg::KIND_CHECK, $urandom);
            else if (pick < 22)
                send_request(arw_pkg::KIND_CHECK, win_start + $urandom_range(0, 48) - 8);
            else
                send_request(arw_pkg::KIND_CHECK,
                             win_start + $urandom_range(0,
                                 $urandom_range(0, arw_pkg::WINDOW_SIZE - 1)));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = arw_pkg::KIND_CHECK;
        seq_num    = '0;
        win_start  = '0;
        head_pos   = '0;
        seen_map   = '0;
        ready_hold = 0;
        err_count  = 0;
        idle_mode  = IDLE_HEAVY;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_initial_latch();
        idle_mode = IDLE_NONE;
        test_full_window();
        idle_mode = IDLE_LIGHT;
        test_seq_wrap();
        test_extremes();
        wait_for_results();
        test_random_traffic();

        wait_for_results();
        repeat (20) @(posedge clk);
        if (err_count == 0 && expected_verdicts.size() == 0)
            $display("[anti_replay_window_check] OK");
        else
            $display("[anti_replay_window_check] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("%0t: timeout, %0d results still pending", $time, expected_verdicts.size());
        $display("[anti_replay_window_check] ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/arw_pkg.sv
hw/rtl/arw_datapath.sv
hw/rtl/arw_ctrl.sv
hw/rtl/anti_replay_window_check.sv
tb/testbench.sv
